### rtl/svf_pkg.sv
// Shared types and constants for the state variable filter.
`timescale 1ns / 1ps
package svf_pkg;

   localparam int STATE_W    = 32;
   localparam int STATE_FRAC = 24;
   localparam int COEF_W     = 32;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_G    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_K    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_A1   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_A2   = 3'd4;

   localparam logic [MODE_W-1:0] MODE_LOWPASS  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_HIGHPASS = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ALLPASS  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_A1,
      ST_MUL_A2,
      ST_SUM_V1,
      ST_MUL_G,
      ST_MUL_K,
      ST_MAKE_Y,
      ST_OUT
   } svf_state_type;

   typedef enum logic [1:0] {
      MUL_A1,
      MUL_A2,
      MUL_G,
      MUL_K
   } svf_mul_sel_type;

   typedef struct packed {
      logic            load;
      logic            mul_en;
      svf_mul_sel_type mul_sel;
      logic            d_en;
      logic            acc_en;
      logic            v1_en;
      logic            v2_en;
      logic            y_en;
      logic            out_en;
   } svf_cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [COEF_W-1:0] g;
      logic [COEF_W-1:0] k;
      logic [COEF_W-1:0] a1;
      logic [COEF_W-1:0] a2;
   } svf_coef_type;

endpackage

### rtl/svf_regs.sv
// Configuration register file for the filter mode and coefficients.
`timescale 1ns / 1ps
module svf_regs (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [svf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [svf_pkg::CSR_DATA_W-1:0]   csr_data,
   output svf_pkg::svf_coef_type            coef
);

   svf_pkg::svf_coef_type coef_ff;
   svf_pkg::svf_coef_type coef_in;

   assign csr_ready = 1'b1;
   assign coef      = coef_ff;

   always_comb begin
      coef_in = coef_ff;
      if (csr_valid) begin
         case (csr_index)
            svf_pkg::CSR_MODE: coef_in.mode = csr_data[svf_pkg::MODE_W-1:0];
            svf_pkg::CSR_G:    coef_in.g    = csr_data[svf_pkg::COEF_W-1:0];
            svf_pkg::CSR_K:    coef_in.k    = csr_data[svf_pkg::COEF_W-1:0];
            svf_pkg::CSR_A1:   coef_in.a1   = csr_data[svf_pkg::COEF_W-1:0];
            svf_pkg::CSR_A2:   coef_in.a2   = csr_data[svf_pkg::COEF_W-1:0];
            default:           coef_in      = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

endmodule

### rtl/svf_ctrl.sv
// Controller state machine that sequences the shared multiplier.
`timescale 1ns / 1ps
module svf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output svf_pkg::svf_cmd_type cmd
);

   svf_pkg::svf_state_type state_ff;
   svf_pkg::svf_state_type state_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.mul_sel  = svf_pkg::MUL_A1;
      case (state_ff)
         svf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = svf_pkg::ST_MUL_A1;
            end
         end
         svf_pkg::ST_MUL_A1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = svf_pkg::MUL_A1;
            cmd.d_en    = 1'b1;
            state_in    = svf_pkg::ST_MUL_A2;
         end
         svf_pkg::ST_MUL_A2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = svf_pkg::MUL_A2;
            cmd.acc_en  = 1'b1;
            state_in    = svf_pkg::ST_SUM_V1;
         end
         svf_pkg::ST_SUM_V1: begin
            cmd.v1_en = 1'b1;
            state_in  = svf_pkg::ST_MUL_G;
         end
         svf_pkg::ST_MUL_G: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = svf_pkg::MUL_G;
            state_in    = svf_pkg::ST_MUL_K;
         end
         svf_pkg::ST_MUL_K: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = svf_pkg::MUL_K;
            cmd.v2_en   = 1'b1;
            state_in    = svf_pkg::ST_MAKE_Y;
         end
         svf_pkg::ST_MAKE_Y: begin
            cmd.y_en = 1'b1;
            state_in = svf_pkg::ST_OUT;
         end
         svf_pkg::ST_OUT: begin
            if (out_free) begin
               cmd.out_en   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = svf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = svf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= svf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/svf_dp.sv
// Datapath with the shared multiplier, integrator states and output register.
`timescale 1ns / 1ps
module svf_dp #(
   parameter int SAMPLE_WIDTH   = 24,
   parameter int COEF_FRAC_BITS = 28
) (
   input  logic                           clock,
   input  logic                           reset,
   input  svf_pkg::svf_cmd_type           cmd,
   input  svf_pkg::svf_coef_type          coef,
   input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
   output logic signed [SAMPLE_WIDTH-1:0] sample_out
);

   localparam int SW       = svf_pkg::STATE_W;
   localparam int PROD_W   = svf_pkg::COEF_W + 1 + SW;
   localparam int WIDE_W   = PROD_W + 1;
   localparam int FRAC     = svf_pkg::STATE_FRAC;
   localparam bit IN_UP    = (SAMPLE_WIDTH - 1) <= FRAC;
   localparam int IN_LSH   = IN_UP ? (FRAC - SAMPLE_WIDTH + 1) : 0;
   localparam int IN_RSH   = IN_UP ? 1 : (SAMPLE_WIDTH - 1 - FRAC);
   localparam bit OUT_UP   = (SAMPLE_WIDTH - 1) >= FRAC;
   localparam int OUT_LSH  = OUT_UP ? (SAMPLE_WIDTH - 1 - FRAC) : 0;
   localparam int OUT_RSH  = OUT_UP ? 1 : (FRAC - SAMPLE_WIDTH + 1);

   localparam logic signed [WIDE_W-1:0] ST_MAX =
      {{(WIDE_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
   localparam logic signed [WIDE_W-1:0] ST_MIN =
      {{(WIDE_W-SW+1){1'b1}}, {(SW-1){1'b0}}};
   localparam logic signed [WIDE_W-1:0] SMP_MAX =
      {{(WIDE_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [WIDE_W-1:0] SMP_MIN =
      {{(WIDE_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

   function automatic logic signed [SW-1:0] sat_state(input logic signed [WIDE_W-1:0] x);
      logic signed [SW-1:0] r;
      if (x > ST_MAX) begin
         r = ST_MAX[SW-1:0];
      end else if (x < ST_MIN) begin
         r = ST_MIN[SW-1:0];
      end else begin
         r = x[SW-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [WIDE_W-1:0] ext_state(input logic signed [SW-1:0] x);
      return {{(WIDE_W-SW){x[SW-1]}}, x};
   endfunction

   function automatic logic signed [WIDE_W-1:0] round_prod(
      input logic signed [PROD_W-1:0] p
   );
      logic signed [WIDE_W-1:0] e;
      e = {p[PROD_W-1], p};
      return $signed((e >>> COEF_FRAC_BITS) +
                     $signed({{(WIDE_W-1){1'b0}}, p[COEF_FRAC_BITS-1]}));
   endfunction

   logic signed [SW-1:0]     v0_ff;
   logic signed [SW-1:0]     d_ff;
   logic signed [SW-1:0]     v1_ff;
   logic signed [SW-1:0]     v2_ff;
   logic signed [SW-1:0]     y_ff;
   logic signed [SW-1:0]     ic1_ff;
   logic signed [SW-1:0]     ic2_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [WIDE_W-1:0] acc_ff;
   logic signed [SAMPLE_WIDTH-1:0] sample_out_ff;

   logic signed [SW-1:0]     v0_in;
   logic signed [SW-1:0]     ic1_in;
   logic signed [SW-1:0]     ic2_in;
   logic signed [SW-1:0]     y_in;
   logic signed [SAMPLE_WIDTH-1:0] sample_out_in;
   logic signed [PROD_W-1:0] prod_in;
   logic [svf_pkg::COEF_W-1:0] mul_coef;
   logic signed [SW-1:0]     mul_sig;
   logic signed [WIDE_W-1:0] prod_rnd;
   logic signed [WIDE_W-1:0] samp_ext;
   logic signed [WIDE_W-1:0] v0_wide;
   logic signed [WIDE_W-1:0] y_wide;
   logic signed [WIDE_W-1:0] y_scaled;
   logic signed [WIDE_W-1:0] hp_sum;
   logic signed [WIDE_W-1:0] ap_sum;

   assign samp_ext = {{(WIDE_W-SAMPLE_WIDTH){sample_in[SAMPLE_WIDTH-1]}}, sample_in};
   assign y_wide   = ext_state(y_ff);

   generate
      if (IN_UP) begin : g_in_up
         assign v0_wide = samp_ext <<< IN_LSH;
      end else begin : g_in_down
         assign v0_wide = $signed((samp_ext >>> IN_RSH) +
                                  $signed({{(WIDE_W-1){1'b0}}, samp_ext[IN_RSH-1]}));
      end
      if (OUT_UP) begin : g_out_up
         assign y_scaled = y_wide <<< OUT_LSH;
      end else begin : g_out_down
         assign y_scaled = $signed((y_wide >>> OUT_RSH) +
                                   $signed({{(WIDE_W-1){1'b0}}, y_wide[OUT_RSH-1]}));
      end
   endgenerate

   assign v0_in    = sat_state(v0_wide);
   assign prod_rnd = round_prod(prod_ff);

   always_comb begin
      case (cmd.mul_sel)
         svf_pkg::MUL_A1: begin
            mul_coef = coef.a1;
            mul_sig  = ic1_ff;
         end
         svf_pkg::MUL_A2: begin
            mul_coef = coef.a2;
            mul_sig  = d_ff;
         end
         svf_pkg::MUL_G: begin
            mul_coef = coef.g;
            mul_sig  = v1_ff;
         end
         svf_pkg::MUL_K: begin
            mul_coef = coef.k;
            mul_sig  = v1_ff;
         end
         default: begin
            mul_coef = coef.a1;
            mul_sig  = ic1_ff;
         end
      endcase
   end

   assign prod_in = $signed({1'b0, mul_coef}) * mul_sig;

   // In the output step the pending product is k times the band signal.
   assign hp_sum = ext_state(v0_ff) - prod_rnd - ext_state(v2_ff);
   assign ap_sum = ext_state(v0_ff) - (prod_rnd <<< 1);

   always_comb begin
      case (coef.mode)
         svf_pkg::MODE_LOWPASS:  y_in = v2_ff;
         svf_pkg::MODE_HIGHPASS: y_in = sat_state(hp_sum);
         default:                y_in = sat_state(ap_sum);
      endcase
   end

   assign ic1_in = sat_state((ext_state(v1_ff) <<< 1) - ext_state(ic1_ff));
   assign ic2_in = sat_state((ext_state(v2_ff) <<< 1) - ext_state(ic2_ff));

   always_comb begin
      if (y_scaled > SMP_MAX) begin
         sample_out_in = SMP_MAX[SAMPLE_WIDTH-1:0];
      end else if (y_scaled < SMP_MIN) begin
         sample_out_in = SMP_MIN[SAMPLE_WIDTH-1:0];
      end else begin
         sample_out_in = y_scaled[SAMPLE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ic1_ff <= '0;
         ic2_ff <= '0;
      end else if (cmd.y_en) begin
         ic1_ff <= ic1_in;
         ic2_ff <= ic2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         v0_ff <= v0_in;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.d_en) begin
         d_ff <= sat_state(ext_state(v0_ff) - ext_state(ic2_ff));
      end
      if (cmd.acc_en) begin
         acc_ff <= prod_rnd;
      end
      if (cmd.v1_en) begin
         v1_ff <= sat_state(acc_ff + prod_rnd);
      end
      if (cmd.v2_en) begin
         v2_ff <= sat_state(ext_state(ic2_ff) + prod_rnd);
      end
      if (cmd.y_en) begin
         y_ff <= y_in;
      end
      if (cmd.out_en) begin
         sample_out_ff <= sample_out_in;
      end
   end

   assign sample_out = sample_out_ff;

endmodule

### rtl/state_variable_filter.sv
// Top level of the trapezoidal state variable filter.
//
// One signed sample enters on the request channel (req_valid, req_ready,
// req_sample_in) and one filtered sample leaves on the response channel
// (rsp_valid, rsp_ready, rsp_sample_out). The mode and the four
// precomputed coefficients are written through the csr_ channel, which
// is always ready and should only be written while no request is in work.
// A request runs through the controller states in order: it accepts and
// scales the sample, forms four products on one shared 33 by 32 bit
// multiplier with the sums between them, forms the output and updates
// both integrators, and loads the output register. The response is valid
// once that register is loaded, and no new request is taken before then.
// The output register holds a finished sample while the receiver stalls;
// the next request is still accepted and worked on, and it waits in its
// last step until the output register is free.
// Reset is synchronous: it clears the mode and coefficients to zero, empties
// the output register and zeroes both integrator states.
`timescale 1ns / 1ps
module state_variable_filter #(
   parameter int SAMPLE_WIDTH   = 24,
   parameter int COEF_FRAC_BITS = 28
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]        req_sample_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]        rsp_sample_out,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [svf_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [svf_pkg::CSR_DATA_W-1:0]        csr_data
);

   svf_pkg::svf_coef_type coef;
   svf_pkg::svf_cmd_type  cmd;

   svf_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .coef      (coef)
   );

   svf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   svf_dp #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .coef       (coef),
      .sample_in  (req_sample_in),
      .sample_out (rsp_sample_out)
   );

endmodule

### rtl/svf_checker.sv
// Port-level checks for the state variable filter and their binding.
`timescale 1ns / 1ps
module svf_checker #(
   parameter int SAMPLE_WIDTH = 24
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [SAMPLE_WIDTH-1:0] rsp_sample_out
);

   // A stalled response keeps its sample.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out))
      else $error("response changed while stalled");

   // Only one request is in work at a time.
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in work");

   // An accepted request leads to a response on offer.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##8 rsp_valid)
      else $error("response missing after request");

   // Reset leaves no response on offer.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind state_variable_filter svf_checker #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_svf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_sample_out (rsp_sample_out)
);

### tb/state_variable_filter_test.sv
// Self-checking testbench for the state variable filter with a bit-exact sample predictor.
`timescale 1ns / 1ps
module state_variable_filter_test;

   localparam int     SAMPLE_WIDTH   = 24;
   localparam int     COEF_FRAC_BITS = 28;
   localparam int     SCALE_SHIFT    = svf_pkg::STATE_FRAC - (SAMPLE_WIDTH - 1);
   localparam longint STATE_MAX      = 64'sd2147483647;
   localparam longint STATE_MIN      = -64'sd2147483648;
   localparam longint SAMPLE_MAX     = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1;
   localparam longint SAMPLE_MIN     = -(64'sd1 <<< (SAMPLE_WIDTH - 1));
   localparam int     LONG_STALL     = 300;
   localparam int     PHASES         = 12;
   localparam int     PHASE_ITEMS    = 120;
   localparam int     CYCLE_LIMIT    = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [SAMPLE_WIDTH-1:0] req_sample_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_out;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [svf_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [svf_pkg::CSR_DATA_W-1:0] csr_data = '0;

   logic signed [SAMPLE_WIDTH-1:0] sample_q[$];
   logic signed [SAMPLE_WIDTH-1:0] filtered_q[$];
   int item_count = 0;
   int rsp_count = 0;
   int error_count = 0;
   int setting_count = 0;
   int cycle_count = 0;
   int send_gap_pct = 0;
   int recv_gap_pct = 0;
   int stall_orders = 0;
   int stall_served = 0;
   int stall_left = 0;

   logic [svf_pkg::MODE_W-1:0] m_mode = svf_pkg::MODE_LOWPASS;
   logic [svf_pkg::COEF_W-1:0] m_g = '0;
   logic [svf_pkg::COEF_W-1:0] m_k = '0;
   logic [svf_pkg::COEF_W-1:0] m_a1 = '0;
   logic [svf_pkg::COEF_W-1:0] m_a2 = '0;
   longint band_state = 0;
   longint low_state = 0;

   state_variable_filter #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sample_in(req_sample_in),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_sample_out(rsp_sample_out),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   function automatic longint round_shift(longint x, int n);
      return (x >>> n) + ((x >>> (n - 1)) & 64'sd1);
   endfunction

   function automatic longint clamp(longint x, longint lo, longint hi);
      if (x < lo) return lo;
      if (x > hi) return hi;
      return x;
   endfunction

   function automatic longint coef_mul(logic [svf_pkg::COEF_W-1:0] c, longint s);
      longint p;
      p = $signed({32'd0, c}) * s;
      return round_shift(p, COEF_FRAC_BITS);
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] filter_sample(
      logic signed [SAMPLE_WIDTH-1:0] x);
      longint v0, d, v1, v2, kv1, y;
      v0 = clamp(longint'(x) <<< SCALE_SHIFT, STATE_MIN, STATE_MAX);
      d = clamp(v0 - low_state, STATE_MIN, STATE_MAX);
      v1 = clamp(coef_mul(m_a1, band_state) + coef_mul(m_a2, d), STATE_MIN, STATE_MAX);
      v2 = clamp(low_state + coef_mul(m_g, v1), STATE_MIN, STATE_MAX);
      kv1 = coef_mul(m_k, v1);
      if (m_mode == svf_pkg::MODE_LOWPASS) y = v2;
      else if (m_mode == svf_pkg::MODE_HIGHPASS) y = clamp(v0 - kv1 - v2, STATE_MIN, STATE_MAX);
      else y = clamp(v0 - 2 * kv1, STATE_MIN, STATE_MAX);
      band_state = clamp(2 * v1 - band_state, STATE_MIN, STATE_MAX);
      low_state = clamp(2 * v2 - low_state, STATE_MIN, STATE_MAX);
      y = clamp(round_shift(y, SCALE_SHIFT), SAMPLE_MIN, SAMPLE_MAX);
      return y[SAMPLE_WIDTH-1:0];
   endfunction

   function automatic logic [svf_pkg::COEF_W-1:0] to_coef(real r);
      longint v;
      v = r * (2.0 ** COEF_FRAC_BITS);
      if (v > 64'sd4294967295) v = 64'sd4294967295;
      if (v < 0) v = 0;
      return v[svf_pkg::COEF_W-1:0];
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d of %0d responses.",
                  cycle_count, rsp_count, item_count);
         $display("state_variable_filter_test: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && csr_valid && csr_ready) begin
         case (csr_index)
            svf_pkg::CSR_MODE: m_mode = csr_data[svf_pkg::MODE_W-1:0];
            svf_pkg::CSR_G:    m_g = csr_data[svf_pkg::COEF_W-1:0];
            svf_pkg::CSR_K:    m_k = csr_data[svf_pkg::COEF_W-1:0];
            svf_pkg::CSR_A1:   m_a1 = csr_data[svf_pkg::COEF_W-1:0];
            svf_pkg::CSR_A2:   m_a2 = csr_data[svf_pkg::COEF_W-1:0];
            default: ;
         endcase
      end
   end

   always @(posedge clock) begin : drive_requests
      logic next_valid;
      logic signed [SAMPLE_WIDTH-1:0] next_sample;
      next_valid = req_valid;
      next_sample = req_sample_in;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            filtered_q.push_back(filter_sample(req_sample_in));
            next_valid = 1'b0;
         end
         if (!next_valid && sample_q.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
            next_valid = 1'b1;
            next_sample = sample_q.pop_front();
         end
      end
      req_valid <= next_valid;
      req_sample_in <= next_sample;
   end

   always @(posedge clock) begin : watch_responses
      logic next_ready;
      logic signed [SAMPLE_WIDTH-1:0] want;
      next_ready = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (filtered_q.size() == 0) begin
               $display("%0t: response %0d with no request outstanding", $time,
                        rsp_sample_out);
               error_count++;
            end else begin
               want = filtered_q.pop_front();
               if (rsp_sample_out !== want) begin
                  $display("%0t: sample_out mismatch, expected %0d, actual %0d", $time,
                           want, rsp_sample_out);
                  error_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
         end else if (stall_served != stall_orders) begin
            stall_served++;
            stall_left = LONG_STALL;
         end else begin
            next_ready = ($urandom_range(0, 99) >= recv_gap_pct);
         end
      end
      rsp_ready <= next_ready;
   end

   task automatic csr_write(logic [svf_pkg::CSR_IDX_W-1:0] idx,
                            logic [svf_pkg::CSR_DATA_W-1:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic load_filter(logic [svf_pkg::MODE_W-1:0] mode, logic [svf_pkg::COEF_W-1:0] g,
                              logic [svf_pkg::COEF_W-1:0] k, logic [svf_pkg::COEF_W-1:0] a1,
                              logic [svf_pkg::COEF_W-1:0] a2, bit stray_writes);
      csr_write(svf_pkg::CSR_MODE, ($urandom() & ~32'h3) | mode);
      csr_write(svf_pkg::CSR_G, g);
      csr_write(svf_pkg::CSR_K, k);
      csr_write(svf_pkg::CSR_A1, a1);
      csr_write(svf_pkg::CSR_A2, a2);
      if (stray_writes) begin
         for (int i = svf_pkg::CSR_A2 + 1; i < (1 << svf_pkg::CSR_IDX_W); i++)
            csr_write(i[svf_pkg::CSR_IDX_W-1:0], $urandom());
      end
      csr_valid <= 1'b0;
      setting_count++;
   endtask

   task automatic tune_filter(logic [svf_pkg::MODE_W-1:0] mode, real ratio, real q,
                              bit stray_writes);
      real g, k, a1;
      g = $tan(3.14159265358979 * ratio);
      k = 1.0 / q;
      a1 = 1.0 / (1.0 + g * (g + k));
      load_filter(mode, to_coef(g), to_coef(k), to_coef(a1), to_coef(g * a1), stray_writes);
   endtask

   task automatic send(longint s);
      sample_q.push_back(s[SAMPLE_WIDTH-1:0]);
      item_count++;
   endtask

   task automatic drain;
      while (rsp_count != item_count) @(posedge clock);
   endtask

   initial begin : run
      int n, len, kind, level, pick;
      real amp, step;
      logic [svf_pkg::COEF_W-1:0] c[4];
      send_gap_pct = 22;
      recv_gap_pct = 65;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(SAMPLE_MAX);
      send(SAMPLE_MIN);
      send(0);
      drain();
      tune_filter(svf_pkg::MODE_LOWPASS, 0.05, 0.707, 1'b0);
      send(SAMPLE_MAX); send(SAMPLE_MAX); send(SAMPLE_MIN); send(SAMPLE_MIN);
      send(1); send(-1); send(0);
      drain();
      tune_filter(svf_pkg::MODE_HIGHPASS, 0.05, 0.707, 1'b0);
      send(SAMPLE_MAX); send(SAMPLE_MIN); send(0);
      drain();
      tune_filter(svf_pkg::MODE_ALLPASS, 0.2, 4.0, 1'b0);
      send(SAMPLE_MAX); send(SAMPLE_MIN); send(1);
      drain();
      tune_filter(2'd3, 0.2, 4.0, 1'b1);
      send(SAMPLE_MAX); send(SAMPLE_MIN); send(12345); send(-12345);
      drain();
      load_filter(svf_pkg::MODE_LOWPASS, '1, '1, '1, '1, 1'b0);
      send(SAMPLE_MAX); send(SAMPLE_MAX); send(SAMPLE_MIN);
      drain();
      load_filter(svf_pkg::MODE_ALLPASS, '1, '1, '1, '1, 1'b0);
      send(SAMPLE_MAX); send(SAMPLE_MIN);
      drain();

      for (int p = 0; p < PHASES; p++) begin
         if (p < PHASES / 3) begin
            send_gap_pct = 22;
            recv_gap_pct = 65;
         end else if (p < 2 * PHASES / 3) begin
            send_gap_pct = 65;
            recv_gap_pct = 22;
         end else begin
            send_gap_pct = 0;
            recv_gap_pct = 0;
         end
         kind = $urandom_range(0, 5);
         pick = $urandom_range(0, 3);
         if (kind <= 2) begin
            tune_filter(pick[svf_pkg::MODE_W-1:0], $urandom_range(1, 450) / 1000.0,
                        $urandom_range(50, 2000) / 100.0, $urandom_range(0, 3) == 0);
         end else begin
            for (int i = 0; i < 4; i++) begin
               if (kind == 3) c[i] = $urandom();
               else if (kind == 4) c[i] = $urandom_range(0, 32'h2000_0000);
               else c[i] = $urandom_range(0, 1) ? '1 : '0;
            end
            load_filter(pick[svf_pkg::MODE_W-1:0], c[0], c[1], c[2], c[3],
                        $urandom_range(0, 3) == 0);
         end
         if (p == 2 * PHASES / 3) stall_orders++;
         n = 0;
         while (n < PHASE_ITEMS) begin
            if (p == PHASES / 2 && n >= PHASE_ITEMS / 2 && n < PHASE_ITEMS / 2 + 4) drain();
            kind = $urandom_range(0, 3);
            len = $urandom_range(4, 24);
            amp = $urandom_range(1, 1000) / 1000.0;
            step = $urandom_range(1, 900) / 1000.0;
            level = $urandom_range(0, 2);
            for (int i = 0; i < len && n < PHASE_ITEMS; i++, n++) begin
               case (kind)
                  0: send(longint'($urandom()));
                  1: send(longint'(amp * $sin(3.14159265358979 * step * i) * SAMPLE_MAX));
                  2: send(level == 0 ? SAMPLE_MAX : level == 1 ? SAMPLE_MIN : longint'(amp * SAMPLE_MAX));
                  default: send(longint'($urandom_range(0, 2047)) - 1024);
               endcase
            end
         end
         drain();
      end

      repeat (20) @(posedge clock);
      if (filtered_q.size() != 0) begin
         $display("%0t: %0d expected samples never arrived", $time, filtered_q.size());
         error_count++;
      end
      $display("Filtered %0d samples under %0d coefficient settings in every mode,",
               item_count, setting_count);
      $display("with saturating coefficients, stray register writes and a %0d-cycle stall.",
               LONG_STALL);
      if (error_count == 0) begin
         $display("state_variable_filter_test: PASS");
      end else begin
         $display("state_variable_filter_test: FAIL");
      end
      $finish;
   end

endmodule

### files.f
rtl/svf_pkg.sv
rtl/svf_regs.sv
rtl/svf_ctrl.sv
rtl/svf_dp.sv
rtl/state_variable_filter.sv
rtl/svf_checker.sv
tb/state_variable_filter_test.sv
